// ===== src/stfc_pkg.sv =====
// stfc_pkg: shared types, constants and helpers for the sorted table search core
// holds the channel payload structs and the search token carried along the cell chain
// no dependencies
package stfc_pkg;

  // position width: covers table depths up to 8191 with room for a -1 high bound
  localparam int unsigned POS_W = 14;

  localparam logic [1:0] ACT_APPEND = 2'd0;
  localparam logic [1:0] ACT_QUERY  = 2'd1;
  localparam logic [1:0] ACT_CLEAR  = 2'd2;

  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;

  typedef logic signed [POS_W-1:0] pos_t;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] item_value;
  } in_item_t;

  typedef struct packed {
    logic               floor_found;
    logic signed [31:0] floor_value;
    logic               ceil_found;
    logic signed [31:0] ceil_value;
  } out_item_t;

  // state of one binary search
  typedef struct packed {
    pos_t               lo;
    pos_t               hi;
    logic               found;
    logic               done;
    logic signed [31:0] best;
  } search_t;

  // search token handed from cell to cell
  typedef struct packed {
    logic               valid;
    logic signed [31:0] key;
    search_t            flr;
    search_t            cel;
  } token_t;

  // midpoint rounded down, for lo <= hi with both non-negative
  function automatic pos_t mid_of(input pos_t lo, input pos_t hi);
    logic signed [POS_W:0] sum;
    sum = {lo[POS_W-1], lo} + {hi[POS_W-1], hi};
    return sum[POS_W:1];
  endfunction

endpackage

// ===== src/stfc_cell.sv =====
// stfc_cell: one probe cell of the search chain
// holds a token, applies one floor probe and one ceiling probe, hands the result on
// depends on stfc_pkg
module stfc_cell (
  input  logic                  clk,
  input  logic                  rst_n,
  input  stfc_pkg::token_t      tok_in,
  input  logic signed [31:0]    rd_flr,
  input  logic signed [31:0]    rd_cel,
  output stfc_pkg::token_t      tok_out,
  output stfc_pkg::pos_t        mid_flr,
  output stfc_pkg::pos_t        mid_cel,
  output logic                  active
);

  stfc_pkg::token_t tok_r;
  stfc_pkg::token_t tok_nxt;
  stfc_pkg::pos_t   m_f;
  stfc_pkg::pos_t   m_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_in;
    end
  end

  always_comb begin
    tok_nxt = tok_r;
    m_f     = stfc_pkg::mid_of(tok_r.flr.lo, tok_r.flr.hi);
    m_c     = stfc_pkg::mid_of(tok_r.cel.lo, tok_r.cel.hi);

    // floor probe
    if (tok_r.valid && !tok_r.flr.done) begin
      if (rd_flr == tok_r.key) begin
        tok_nxt.flr.best  = rd_flr;
        tok_nxt.flr.found = 1'b1;
        tok_nxt.flr.done  = 1'b1;
      end else if (rd_flr < tok_r.key) begin
        tok_nxt.flr.best  = rd_flr;
        tok_nxt.flr.found = 1'b1;
        tok_nxt.flr.lo    = m_f + stfc_pkg::pos_t'(1);
      end else begin
        tok_nxt.flr.hi    = m_f - stfc_pkg::pos_t'(1);
      end
      if (tok_nxt.flr.lo > tok_nxt.flr.hi) begin
        tok_nxt.flr.done = 1'b1;
      end
    end

    // ceiling probe
    if (tok_r.valid && !tok_r.cel.done) begin
      if (rd_cel == tok_r.key) begin
        tok_nxt.cel.best  = rd_cel;
        tok_nxt.cel.found = 1'b1;
        tok_nxt.cel.done  = 1'b1;
      end else if (rd_cel > tok_r.key) begin
        tok_nxt.cel.best  = rd_cel;
        tok_nxt.cel.found = 1'b1;
        tok_nxt.cel.hi    = m_c - stfc_pkg::pos_t'(1);
      end else begin
        tok_nxt.cel.lo    = m_c + stfc_pkg::pos_t'(1);
      end
      if (tok_nxt.cel.lo > tok_nxt.cel.hi) begin
        tok_nxt.cel.done = 1'b1;
      end
    end
  end

  assign tok_out = tok_nxt;
  assign mid_flr = stfc_pkg::mid_of(tok_nxt.flr.lo, tok_nxt.flr.hi);
  assign mid_cel = stfc_pkg::mid_of(tok_nxt.cel.lo, tok_nxt.cel.hi);
  assign active  = tok_r.valid;

endmodule

// ===== src/sorted_table_floor_ceil_search_core.sv =====
// sorted_table_floor_ceil_search_core: floor and ceiling lookup over an append-only table
// a query runs through the NCELL = clog2(TABLE_DEPTH+1) probe cells and then the output register
// one query in flight at a time; new transactions stall until the chain is empty and no result is blocked
// append and clear transactions give no result
// reset: entry count and all control state cleared; table contents need no clearing
// depends on stfc_pkg and stfc_cell
module sorted_table_floor_ceil_search_core #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  stfc_pkg::in_item_t   in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output stfc_pkg::out_item_t  out_item
);

  // one cell per probe: worst case search length over a full table
  localparam int NCELL = $clog2(TABLE_DEPTH + 1);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  // table storage, one write port and two read ports with registered data
  logic signed [31:0] mem [TABLE_DEPTH];
  logic signed [31:0] rd_flr_r;
  logic signed [31:0] rd_cel_r;
  logic [AW-1:0]      rd_addr_flr;
  logic [AW-1:0]      rd_addr_cel;

  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   count_nxt;

  logic               in_accept;
  logic               busy;
  logic               append_we;

  stfc_pkg::token_t   tok_chain [NCELL+1];
  stfc_pkg::pos_t     cell_mid_flr [NCELL];
  stfc_pkg::pos_t     cell_mid_cel [NCELL];
  logic [NCELL-1:0]   cell_active;
  stfc_pkg::pos_t     entry_mid_flr;
  stfc_pkg::pos_t     entry_mid_cel;

  logic               out_valid_r;
  stfc_pkg::out_item_t out_item_r;

  // only one query travels the chain; hold off while it runs or a result is blocked
  assign busy      = |cell_active;
  assign in_stall  = busy | (out_valid_r & out_stall);
  assign in_accept = in_valid & ~in_stall;
  assign append_we = in_accept && (in_item.action == stfc_pkg::ACT_APPEND)
                     && (count_r < CNT_W'(TABLE_DEPTH));

  // entry count: appends beyond capacity dropped, clear empties the table
  always_comb begin
    count_nxt = count_r;
    if (in_accept) begin
      case (in_item.action)
        stfc_pkg::ACT_APPEND: begin
          if (append_we) begin
            count_nxt = count_r + CNT_W'(1);
          end
        end
        stfc_pkg::ACT_CLEAR: begin
          count_nxt = '0;
        end
        default: begin
          count_nxt = count_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // search token entering the chain; an empty table finishes both searches at once
  always_comb begin
    tok_chain[0].valid     = in_accept && (in_item.action == stfc_pkg::ACT_QUERY);
    tok_chain[0].key       = in_item.item_value;
    tok_chain[0].flr.lo    = '0;
    tok_chain[0].flr.hi    = stfc_pkg::pos_t'(count_r) - stfc_pkg::pos_t'(1);
    tok_chain[0].flr.found = 1'b0;
    tok_chain[0].flr.done  = (count_r == '0);
    tok_chain[0].flr.best  = stfc_pkg::VAL_MIN;
    tok_chain[0].cel.lo    = '0;
    tok_chain[0].cel.hi    = stfc_pkg::pos_t'(count_r) - stfc_pkg::pos_t'(1);
    tok_chain[0].cel.found = 1'b0;
    tok_chain[0].cel.done  = (count_r == '0);
    tok_chain[0].cel.best  = stfc_pkg::VAL_MAX;
  end

  assign entry_mid_flr = stfc_pkg::mid_of(tok_chain[0].flr.lo, tok_chain[0].flr.hi);
  assign entry_mid_cel = stfc_pkg::mid_of(tok_chain[0].cel.lo, tok_chain[0].cel.hi);

  // probe cell chain: each cell consumes the read data for its midpoint
  // and issues the next midpoint to the table in the same cycle
  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    stfc_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .tok_in  (tok_chain[i]),
      .rd_flr  (rd_flr_r),
      .rd_cel  (rd_cel_r),
      .tok_out (tok_chain[i+1]),
      .mid_flr (cell_mid_flr[i]),
      .mid_cel (cell_mid_cel[i]),
      .active  (cell_active[i])
    );
  end

  // read address from whichever cell holds the token, else from the new query
  always_comb begin
    rd_addr_flr = entry_mid_flr[AW-1:0];
    rd_addr_cel = entry_mid_cel[AW-1:0];
    for (int i = 0; i < NCELL; i++) begin
      if (cell_active[i]) begin
        rd_addr_flr = cell_mid_flr[i][AW-1:0];
        rd_addr_cel = cell_mid_cel[i][AW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (append_we) begin
      mem[count_r[AW-1:0]] <= in_item.item_value;
    end
    rd_flr_r <= mem[rd_addr_flr];
    rd_cel_r <= mem[rd_addr_cel];
  end

  // output register; the chain tail is only valid when this register is free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (tok_chain[NCELL].valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tok_chain[NCELL].valid) begin
      out_item_r.floor_found <= tok_chain[NCELL].flr.found;
      out_item_r.floor_value <= tok_chain[NCELL].flr.best;
      out_item_r.ceil_found  <= tok_chain[NCELL].cel.found;
      out_item_r.ceil_value  <= tok_chain[NCELL].cel.best;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
